[src/wild_pkg.sv]
// ----------------------------------------------------------------------------
// wild_pkg
// shared types, opcode constants and opcode class helpers for the
// webassembly instruction length decoder
// ----------------------------------------------------------------------------
package wild_pkg;

    localparam logic [7:0] OPC_END           = 8'h0b;
    localparam logic [7:0] OPC_CALL_INDIRECT = 8'h11;
    localparam logic [7:0] OPC_GET_GLOBAL    = 8'h23;
    localparam logic [7:0] OPC_I32_CONST     = 8'h41;
    localparam logic [7:0] OPC_F64_CONST     = 8'h44;

    typedef struct packed {
        logic       valid;
        logic [7:0] opcode;
        logic       init_legal;
        logic       error;
    } t_res;

    function automatic logic is_init_opcode(input logic [7:0] op);
        return (op == OPC_END) || (op == OPC_GET_GLOBAL) ||
               ((op >= OPC_I32_CONST) && (op <= OPC_F64_CONST));
    endfunction

endpackage

[src/wasm_instruction_length_decoder_top.sv]
// ----------------------------------------------------------------------------
// wasm_instruction_length_decoder_top
// webassembly mvp instruction length decoder, one code byte per beat
//
//   channel   direction  handshake                   payload
//   in        sink       i_in_valid / o_in_stall     i_code_byte
//   out       source     o_out_valid / i_out_stall   o_opcode, o_byte_length,
//                                                    o_init_legal, o_error
//   cfg       sink       i_cfg_valid / o_cfg_ready   i_expression_mode
//
// one byte accepted per cycle while the output side keeps moving
// a result passes one input register, the decode logic and one result register
// on its way from its last byte to the out channel
// synchronous active-low reset returns decoding to an opcode boundary
// an output stall backs up into the input stage and then into o_in_stall
// ----------------------------------------------------------------------------
module wasm_instruction_length_decoder_top import wild_pkg::*; #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_expression_mode,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [7:0]             i_code_byte,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [7:0]             o_opcode,
    output logic [LENGTH_BITS-1:0] o_byte_length,
    output logic                   o_init_legal,
    output logic                   o_error
);

    logic                   advance;
    logic                   in_valid;
    logic [7:0]             in_byte;
    t_res                   res;
    logic [LENGTH_BITS-1:0] res_length;

    assign o_cfg_ready = 1'b1;

    wild_in_stage u_in (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_code_byte (i_code_byte),
        .i_advance   (advance),
        .o_valid     (in_valid),
        .o_byte      (in_byte)
    );

    wild_dec #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_dec (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_expression_mode (i_expression_mode),
        .i_step            (in_valid && advance),
        .i_byte            (in_byte),
        .o_res             (res),
        .o_length          (res_length)
    );

    wild_out_stage #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_res         ('{valid: res.valid && in_valid && advance, opcode: res.opcode,
                          init_legal: res.init_legal, error: res.error}),
        .i_length      (res_length),
        .o_advance     (advance),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_opcode      (o_opcode),
        .o_byte_length (o_byte_length),
        .o_init_legal  (o_init_legal),
        .o_error       (o_error)
    );

endmodule

[src/wild_in_stage.sv]
// ----------------------------------------------------------------------------
// wild_in_stage
// input register for code bytes, stalls only when the held beat cannot move
// ----------------------------------------------------------------------------
module wild_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_code_byte,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_in_stall = r_valid && !i_advance;
    assign o_valid    = r_valid;
    assign o_byte     = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_byte <= i_code_byte;
        end
    end

endmodule

[src/wild_out_stage.sv]
// ----------------------------------------------------------------------------
// wild_out_stage
// result register, frees itself when the downstream beat is taken
// ----------------------------------------------------------------------------
module wild_out_stage import wild_pkg::*; #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_res                   i_res,
    input  logic [LENGTH_BITS-1:0] i_length,
    output logic                   o_advance,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [7:0]             o_opcode,
    output logic [LENGTH_BITS-1:0] o_byte_length,
    output logic                   o_init_legal,
    output logic                   o_error
);

    logic                   r_valid;
    logic [7:0]             r_opcode;
    logic [LENGTH_BITS-1:0] r_length;
    logic                   r_legal;
    logic                   r_error;

    assign o_advance     = !r_valid || !i_out_stall;
    assign o_out_valid   = r_valid;
    assign o_opcode      = r_opcode;
    assign o_byte_length = r_length;
    assign o_init_legal  = r_legal;
    assign o_error       = r_error;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_res.valid) begin
            r_opcode <= i_res.opcode;
            r_length <= i_length;
            r_legal  <= i_res.init_legal;
            r_error  <= i_res.error;
        end
    end

endmodule

[src/wild_dec.sv]
// ----------------------------------------------------------------------------
// wild_dec
// per-byte decode state: immediate skipping, leb tracking, length counters,
// expression mode register
// ----------------------------------------------------------------------------
module wild_dec import wild_pkg::*; #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic                   i_expression_mode,
    input  logic                   i_step,
    input  logic [7:0]             i_byte,
    output t_res                   o_res,
    output logic [LENGTH_BITS-1:0] o_length
);

    localparam logic [2:0] PH_OPCODE = 3'd0;
    localparam logic [2:0] PH_LEB1   = 3'd1;
    localparam logic [2:0] PH_LEB5   = 3'd2;
    localparam logic [2:0] PH_LEB10  = 3'd3;
    localparam logic [2:0] PH_COUNT  = 3'd4;
    localparam logic [2:0] PH_RAW    = 3'd5;

    logic                   r_mode;
    logic [2:0]             r_phase,  n_phase;
    logic [7:0]             r_cur,    n_cur;
    logic [3:0]             r_seen,   n_seen;
    logic [32:0]            r_left,   n_left;
    logic [31:0]            r_acc,    n_acc;
    logic [3:0]             r_raw,    n_raw;
    logic [LENGTH_BITS-1:0] r_il,     n_il;
    logic [LENGTH_BITS-1:0] r_el,     n_el;
    logic                   r_legal,  n_legal;

    logic [LENGTH_BITS-1:0] il_base;
    logic [LENGTH_BITS-1:0] il_inc;
    logic [LENGTH_BITS-1:0] el_inc;
    logic [7:0]             cur;
    logic [3:0]             seen_inc;
    logic [3:0]             max_bytes;
    logic [32:0]            left_dec;
    logic [3:0]             raw_dec;
    logic [31:0]            acc_part;
    logic [31:0]            acc_upd;
    logic                   done;
    logic                   err;
    logic                   legal_acc;

    always_comb begin
        n_phase  = r_phase;
        n_cur    = r_cur;
        n_seen   = r_seen;
        n_left   = r_left;
        n_acc    = r_acc;
        n_raw    = r_raw;
        n_legal  = r_legal;
        done     = 1'b0;
        err      = 1'b0;
        o_res    = '0;
        o_length = '0;

        il_base   = (r_phase == PH_OPCODE) ? '0 : r_il;
        il_inc    = (&il_base) ? il_base : il_base + LENGTH_BITS'(1);
        el_inc    = (&r_el) ? r_el : r_el + LENGTH_BITS'(1);
        cur       = (r_phase == PH_OPCODE) ? i_byte : r_cur;
        seen_inc  = r_seen + 4'd1;
        left_dec  = (r_left == '0) ? r_left : r_left - 33'd1;
        raw_dec   = (r_raw == '0) ? r_raw : r_raw - 4'd1;
        max_bytes = (r_phase == PH_LEB1) ? 4'd1 : (r_phase == PH_LEB5) ? 4'd5 : 4'd10;
        legal_acc = 1'b0;

        case (r_seen)
            4'd0:    acc_part = {25'd0, i_byte[6:0]};
            4'd1:    acc_part = {18'd0, i_byte[6:0], 7'd0};
            4'd2:    acc_part = {11'd0, i_byte[6:0], 14'd0};
            4'd3:    acc_part = {4'd0, i_byte[6:0], 21'd0};
            4'd4:    acc_part = {i_byte[3:0], 28'd0};
            default: acc_part = '0;
        endcase
        acc_upd = r_acc | acc_part;

        unique case (r_phase)
            PH_OPCODE: begin
                n_cur = i_byte;
                n_acc = '0;
                unique case (i_byte) inside
                    [8'h02:8'h04], 8'h3f, 8'h40: begin
                        n_phase = PH_LEB1;
                        n_seen  = '0;
                        n_left  = 33'd1;
                    end
                    8'h0c, 8'h0d, 8'h10, OPC_CALL_INDIRECT, [8'h20:8'h24], OPC_I32_CONST: begin
                        n_phase = PH_LEB5;
                        n_seen  = '0;
                        n_left  = 33'd1;
                    end
                    [8'h28:8'h3e]: begin
                        n_phase = PH_LEB5;
                        n_seen  = '0;
                        n_left  = 33'd2;
                    end
                    8'h42: begin
                        n_phase = PH_LEB10;
                        n_seen  = '0;
                        n_left  = 33'd1;
                    end
                    8'h0e: begin
                        n_phase = PH_COUNT;
                        n_seen  = '0;
                        n_left  = '0;
                    end
                    8'h43: begin
                        n_phase = PH_RAW;
                        n_raw   = 4'd4;
                    end
                    OPC_F64_CONST: begin
                        n_phase = PH_RAW;
                        n_raw   = 4'd8;
                    end
                    default: begin
                        done = 1'b1;
                    end
                endcase
            end
            PH_LEB1, PH_LEB5, PH_LEB10: begin
                n_seen = seen_inc;
                if (i_byte[7]) begin
                    err = (seen_inc >= max_bytes);
                end else begin
                    n_seen = '0;
                    n_left = left_dec;
                    if (left_dec == '0) begin
                        if (r_phase == PH_LEB5 && r_cur == OPC_CALL_INDIRECT) begin
                            n_phase = PH_LEB1;
                            n_left  = 33'd1;
                        end else begin
                            done = 1'b1;
                        end
                    end
                end
            end
            PH_COUNT: begin
                if (r_seen < 4'd5) begin
                    n_acc = acc_upd;
                end
                n_seen = seen_inc;
                if (i_byte[7]) begin
                    err = (seen_inc >= 4'd5);
                end else begin
                    n_phase = PH_LEB5;
                    n_seen  = '0;
                    n_left  = {1'b0, n_acc} + 33'd1;
                end
            end
            PH_RAW: begin
                n_raw = raw_dec;
                done  = (raw_dec == '0);
            end
            default: begin
                n_phase = PH_OPCODE;
            end
        endcase

        n_il = il_inc;
        n_el = el_inc;

        if (done || err) begin
            n_phase = PH_OPCODE;
            n_seen  = '0;
            n_left  = '0;
            n_raw   = '0;
            if (!r_mode) begin
                o_res.valid      = 1'b1;
                o_res.opcode     = cur;
                o_res.init_legal = is_init_opcode(cur);
                o_res.error      = err;
                o_length         = il_inc;
                n_el             = '0;
                n_legal          = 1'b1;
            end else begin
                legal_acc = r_legal & is_init_opcode(cur);
                n_legal   = legal_acc;
                if (cur == OPC_END || err) begin
                    o_res.valid      = 1'b1;
                    o_res.opcode     = cur;
                    o_res.init_legal = legal_acc;
                    o_res.error      = err;
                    o_length         = el_inc;
                    n_el             = '0;
                    n_legal          = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            r_mode <= i_expression_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OPCODE;
            r_cur   <= '0;
            r_seen  <= '0;
            r_left  <= '0;
            r_acc   <= '0;
            r_raw   <= '0;
            r_il    <= '0;
            r_el    <= '0;
            r_legal <= 1'b1;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cur   <= n_cur;
            r_seen  <= n_seen;
            r_left  <= n_left;
            r_acc   <= n_acc;
            r_raw   <= n_raw;
            r_il    <= n_il;
            r_el    <= n_el;
            r_legal <= n_legal;
        end
    end

    a_raw_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_RAW) |-> (r_raw != '0 && r_raw <= 4'd8))
        else $error("raw byte count out of range");

    a_leb_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LEB1 || r_phase == PH_LEB5 || r_phase == PH_LEB10) |-> (r_left != '0))
        else $error("leb phase with no values left");

    a_leb_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LEB1 || r_phase == PH_LEB5 || r_phase == PH_LEB10) |-> (r_seen < max_bytes))
        else $error("leb byte count past its maximum");

    a_emit_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res.valid) |=> (r_phase == PH_OPCODE))
        else $error("result given without return to opcode");

endmodule
